// File: hw/rtl/sabf_pkg.sv
// ----------------------------------------------------------------------------
// sabf_pkg: shared types and constants of the shape alpha blend fill block
// Frame size, shape mode and register index codes, and the configuration
// bundle that the register file hands to the datapath.
// ----------------------------------------------------------------------------
package sabf_pkg;

   localparam int unsigned FRAME_WIDTH  = 320;
   localparam int unsigned FRAME_HEIGHT = 200;

   // Frame limits at a width that holds the whole parameter range.
   localparam logic [10:0] FRAME_WIDTH_LIMIT  = 11'(FRAME_WIDTH);
   localparam logic [10:0] FRAME_HEIGHT_LIMIT = 11'(FRAME_HEIGHT);

   localparam int unsigned CSR_DATA_WIDTH  = 24;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef enum logic [1:0] {
      SHAPE_RECT    = 2'd0,
      SHAPE_CIRCLE  = 2'd1,
      SHAPE_ROUNDED = 2'd2
   } shape_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHAPE_MODE    = 3'd0,
      CSR_ORIGIN_X      = 3'd1,
      CSR_ORIGIN_Y      = 3'd2,
      CSR_SHAPE_WIDTH   = 3'd3,
      CSR_SHAPE_HEIGHT  = 3'd4,
      CSR_CORNER_RADIUS = 3'd5,
      CSR_FILL_COLOR    = 3'd6,
      CSR_BLEND_ALPHA   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         shape_mode;
      logic signed [10:0] origin_x;
      logic signed [10:0] origin_y;
      logic [9:0]         shape_width;
      logic [9:0]         shape_height;
      logic [7:0]         corner_radius;
      logic [23:0]        fill_color;
      logic [7:0]         blend_alpha;
   } cfg_type;

endpackage

// File: hw/rtl/sabf_csr.sv
// ----------------------------------------------------------------------------
// sabf_csr: configuration register file
// Holds the shape, color and opacity settings written through the plain
// write port and presents them as one bundle.
// ----------------------------------------------------------------------------
module sabf_csr
   import sabf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SHAPE_MODE:    cfg_in.shape_mode    = csr_wdata[1:0];
            CSR_ORIGIN_X:      cfg_in.origin_x      = $signed(csr_wdata[10:0]);
            CSR_ORIGIN_Y:      cfg_in.origin_y      = $signed(csr_wdata[10:0]);
            CSR_SHAPE_WIDTH:   cfg_in.shape_width   = csr_wdata[9:0];
            CSR_SHAPE_HEIGHT:  cfg_in.shape_height  = csr_wdata[9:0];
            CSR_CORNER_RADIUS: cfg_in.corner_radius = csr_wdata[7:0];
            CSR_FILL_COLOR:    cfg_in.fill_color    = csr_wdata[23:0];
            CSR_BLEND_ALPHA:   cfg_in.blend_alpha   = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/sabf_cover.sv
// ----------------------------------------------------------------------------
// sabf_cover: shape coverage test
// Decides whether the configured rectangle, circle or rounded rectangle
// covers one pixel coordinate.
// ----------------------------------------------------------------------------
module sabf_cover
   import sabf_pkg::*;
(
   input  cfg_type    cfg,
   input  logic [8:0] pixel_x,
   input  logic [7:0] pixel_y,
   output logic       covered
);

   logic signed [11:0] col;
   logic signed [11:0] row;
   logic signed [11:0] width_s;
   logic signed [11:0] height_s;
   logic signed [11:0] radius_s;
   logic signed [11:0] width_minus_r;
   logic signed [11:0] height_minus_r;
   logic signed [11:0] dx_full;
   logic signed [11:0] dy_full;
   logic [10:0]        col_abs;
   logic [10:0]        row_abs;
   logic [21:0]        col_sq;
   logic [21:0]        row_sq;
   logic [22:0]        dist_sq;
   logic [15:0]        radius_sq;
   logic [15:0]        dx_sq;
   logic [15:0]        dy_sq;
   logic [16:0]        corner_sq;
   logic               in_rect;
   logic               in_frame;
   logic               circle_hit;
   logic               corner_hit;

   assign col = 12'($signed({3'b000, pixel_x}) - $signed({cfg.origin_x[10], cfg.origin_x}));
   assign row = 12'($signed({4'b0000, pixel_y}) - $signed({cfg.origin_y[10], cfg.origin_y}));
   assign width_s  = $signed({2'b00, cfg.shape_width});
   assign height_s = $signed({2'b00, cfg.shape_height});
   assign radius_s = $signed({4'b0000, cfg.corner_radius});

   assign in_frame = ({2'b00, pixel_x} < FRAME_WIDTH_LIMIT) &&
                     ({3'b000, pixel_y} < FRAME_HEIGHT_LIMIT);
   assign in_rect  = !col[11] && (col < width_s) && !row[11] && (row < height_s);

   // Circle: magnitudes keep the squares unsigned.
   assign col_abs    = col[11] ? 11'(-col) : col[10:0];
   assign row_abs    = row[11] ? 11'(-row) : row[10:0];
   assign col_sq     = col_abs * col_abs;
   assign row_sq     = row_abs * row_abs;
   assign dist_sq    = {1'b0, col_sq} + {1'b0, row_sq};
   assign radius_sq  = cfg.corner_radius * cfg.corner_radius;
   assign circle_hit = dist_sq <= {7'd0, radius_sq};

   // Rounded rectangle: distance into the corner square on each axis.
   assign width_minus_r  = width_s - radius_s;
   assign height_minus_r = height_s - radius_s;

   always_comb begin
      if (col < radius_s) begin
         dx_full = radius_s - col;
      end else if (col >= width_minus_r) begin
         dx_full = col - (width_minus_r - 12'sd1);
      end else begin
         dx_full = '0;
      end
      if (row < radius_s) begin
         dy_full = radius_s - row;
      end else if (row >= height_minus_r) begin
         dy_full = row - (height_minus_r - 12'sd1);
      end else begin
         dy_full = '0;
      end
   end

   // Inside the rectangle both offsets stay within the radius, so eight bits hold them.
   assign dx_sq      = dx_full[7:0] * dx_full[7:0];
   assign dy_sq      = dy_full[7:0] * dy_full[7:0];
   assign corner_sq  = {1'b0, dx_sq} + {1'b0, dy_sq};
   assign corner_hit = corner_sq <= {1'b0, radius_sq};

   always_comb begin
      case (cfg.shape_mode)
         SHAPE_RECT:    covered = in_frame && in_rect;
         SHAPE_CIRCLE:  covered = in_frame && circle_hit;
         SHAPE_ROUNDED: covered = in_frame && in_rect && corner_hit;
         default:       covered = 1'b0;
      endcase
   end

endmodule

// File: hw/rtl/sabf_blend.sv
// ----------------------------------------------------------------------------
// sabf_blend: per-channel alpha blend
// Mixes the fill color into the background pixel on red, green and blue
// and forces the top byte to opaque.
// ----------------------------------------------------------------------------
module sabf_blend
   import sabf_pkg::*;
(
   input  logic [31:0] background_pixel,
   input  logic [23:0] fill_color,
   input  logic [7:0]  blend_alpha,
   output logic [31:0] blended_pixel
);

   // (b*(255-a) + f*a) / 255; the sum never exceeds 255*255, where
   // (x + (x >> 8) + 1) >> 8 gives the exact quotient.
   function automatic logic [7:0] mix_channel(input logic [7:0] b,
                                              input logic [7:0] f,
                                              input logic [7:0] a);
      logic [15:0] mixed;
      logic [15:0] rounded;
      mixed   = ({8'd0, b} * {8'd0, ALPHA_OPAQUE - a}) + ({8'd0, f} * {8'd0, a});
      rounded = mixed + {8'd0, mixed[15:8]} + 16'd1;
      return rounded[15:8];
   endfunction

   assign blended_pixel = {ALPHA_OPAQUE,
                           mix_channel(background_pixel[23:16], fill_color[23:16], blend_alpha),
                           mix_channel(background_pixel[15:8],  fill_color[15:8],  blend_alpha),
                           mix_channel(background_pixel[7:0],   fill_color[7:0],   blend_alpha)};

endmodule

// File: hw/rtl/shape_alpha_blend_fill.sv
// ----------------------------------------------------------------------------
// shape_alpha_blend_fill: per-pixel shape fill with alpha blending
// Tests each pixel against a rectangle, circle or rounded rectangle and
// blends the fill color into the pixels that the shape covers.
// ----------------------------------------------------------------------------
// Usage:
// An item (one pixel: column, row and its current 32-bit value) is taken at
// a rising clock edge where start is high and busy is low. busy is always
// low, so a new item may be offered in every cycle and the block sustains
// one item per clock.
// Each item gives exactly one result. The result appears on rsp_result_pixel
// and rsp_covered for one cycle, marked by rsp_valid. An input register and
// a result register stand around the coverage test and the blend.
// The receiver cannot stall; it must take each result in its cycle.
// Settings are written through csr_write_enable, csr_index and csr_wdata,
// one register per edge, while no item is in flight.
// A synchronous reset clears the settings to zero and drops any item in
// flight; no result leaves for an item that reset caught.
// ----------------------------------------------------------------------------
module shape_alpha_blend_fill
   import sabf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [8:0]                 req_pixel_x,
   input  logic [7:0]                 req_pixel_y,
   input  logic [31:0]                req_background_pixel,
   output logic                       rsp_valid,
   output logic [31:0]                rsp_result_pixel,
   output logic                       rsp_covered,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type     cfg;

   // Input stage: the accepted pixel.
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [8:0]  in_x_ff;
   logic [7:0]  in_y_ff;
   logic [31:0] in_bg_ff;

   // Result stage.
   logic        out_valid_ff;
   logic [31:0] out_pixel_ff;
   logic [31:0] out_pixel_in;
   logic        out_covered_ff;
   logic        covered;
   logic [31:0] blended_pixel;

   // The datapath is fully pipelined, so the block never refuses an item.
   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;

   sabf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   sabf_cover u_cover (
      .cfg     (cfg),
      .pixel_x (in_x_ff),
      .pixel_y (in_y_ff),
      .covered (covered)
   );

   sabf_blend u_blend (
      .background_pixel (in_bg_ff),
      .fill_color       (cfg.fill_color),
      .blend_alpha      (cfg.blend_alpha),
      .blended_pixel    (blended_pixel)
   );

   // An uncovered pixel leaves exactly as it came in.
   assign out_pixel_in = covered ? blended_pixel : in_bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= in_valid_ff;
      end
   end

   // Payload registers carry no reset; the valid bits qualify them.
   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_x_ff  <= req_pixel_x;
         in_y_ff  <= req_pixel_y;
         in_bg_ff <= req_background_pixel;
      end
      out_pixel_ff   <= out_pixel_in;
      out_covered_ff <= covered;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_pixel = out_pixel_ff;
   assign rsp_covered      = out_covered_ff;

endmodule

// File: hw/rtl/sabf_checker.sv
// ----------------------------------------------------------------------------
// sabf_checker: port-level checks of the shape alpha blend fill block
// Watches the item and result ports for timing, pass-through, opacity and frame behavior.
// ----------------------------------------------------------------------------
module sabf_checker
   import sabf_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [8:0]                 req_pixel_x,
   input logic [7:0]                 req_pixel_y,
   input logic [31:0]                req_background_pixel,
   input logic                       rsp_valid,
   input logic [31:0]                rsp_result_pixel,
   input logic                       rsp_covered
);

   // Every accepted item yields a result, through the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy) |-> ##2 rsp_valid)
      else $error("accepted item produced no result");

   // No result without a matching accepted item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, 2))
      else $error("result without an accepted item");

   // An uncovered pixel passes through unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_covered) |-> (rsp_result_pixel == $past(req_background_pixel, 2)))
      else $error("uncovered pixel was altered");

   // A blended pixel is always opaque.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_covered) |-> (rsp_result_pixel[31:24] == ALPHA_OPAQUE))
      else $error("blended pixel is not opaque");

   // Pixels outside the frame are never covered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_covered) |->
         (({2'b00, $past(req_pixel_x, 2)} < FRAME_WIDTH_LIMIT) &&
          ({3'b000, $past(req_pixel_y, 2)} < FRAME_HEIGHT_LIMIT)))
      else $error("pixel outside the frame was covered");

endmodule

bind shape_alpha_blend_fill sabf_checker u_sabf_checker (.*);

// File: tb/sv/sabf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabf_scoreboard: result checker for the shape alpha blend fill block
// Keeps its own copy of the settings from the register port, predicts the
// blended pixel and the coverage flag of every accepted item, and compares
// each result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sabf_scoreboard
   import sabf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [8:0]                 req_pixel_x,
   input  logic [7:0]                 req_pixel_y,
   input  logic [31:0]                req_background_pixel,
   input  logic                       rsp_valid,
   input  logic [31:0]                rsp_result_pixel,
   input  logic                       rsp_covered,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                         mismatch_count,
   output int                         pixels_in_flight
);

   typedef struct packed {
      logic [31:0] pixel;
      logic        covered;
   } blended_pixel_type;

   blended_pixel_type expected_pixels[$];

   logic [1:0]         mode;
   logic signed [10:0] org_x;
   logic signed [10:0] org_y;
   logic [9:0]         box_w;
   logic [9:0]         box_h;
   logic [7:0]         radius;
   logic [23:0]        fill_rgb;
   logic [7:0]         fill_alpha;

   int errors = 0;

   // Distance from the pixel to the arc center of the nearest corner along
   // one axis, zero in the straight part of the edge.
   function automatic int corner_reach(int pos, int size, int r);
      if (pos < r) return r - pos;
      if (pos >= size - r) return pos - (size - r - 1);
      return 0;
   endfunction

   function automatic bit shape_covers(logic [8:0] px, logic [7:0] py);
      int col;
      int row;
      int r;
      int dx;
      int dy;
      bit in_rect;
      col = int'(px) - int'(org_x);
      row = int'(py) - int'(org_y);
      r = int'(radius);
      in_rect = col >= 0 && col < int'(box_w) && row >= 0 && row < int'(box_h);
      if (int'(px) >= int'(FRAME_WIDTH) || int'(py) >= int'(FRAME_HEIGHT)) return 1'b0;
      case (mode)
         SHAPE_RECT: begin
            return in_rect;
         end
         SHAPE_CIRCLE: begin
            return col * col + row * row <= r * r;
         end
         SHAPE_ROUNDED: begin
            if (!in_rect) return 1'b0;
            dx = corner_reach(col, int'(box_w), r);
            dy = corner_reach(row, int'(box_h), r);
            return dx * dx + dy * dy <= r * r;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic logic [31:0] blend_fill(logic [31:0] bg);
      logic [31:0] mixed;
      int a;
      int ch;
      a = int'(fill_alpha);
      mixed = {ALPHA_OPAQUE, 24'h0};
      for (int k = 0; k < 3; k++) begin
         ch = (int'(bg[8*k +: 8]) * (255 - a) + int'(fill_rgb[8*k +: 8]) * a) / 255;
         mixed[8*k +: 8] = 8'(ch);
      end
      return mixed;
   endfunction

   always @(posedge clock) begin
      blended_pixel_type want;
      if (reset) begin
         mode = SHAPE_RECT;
         org_x = '0;
         org_y = '0;
         box_w = '0;
         box_h = '0;
         radius = '0;
         fill_rgb = '0;
         fill_alpha = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t: result with no item waiting: expected none actual %08h %0b",
                        $time, rsp_result_pixel, rsp_covered);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_result_pixel !== want.pixel) begin
                  errors++;
                  $display("%0t: result_pixel expected %08h actual %08h",
                           $time, want.pixel, rsp_result_pixel);
               end
               if (rsp_covered !== want.covered) begin
                  errors++;
                  $display("%0t: covered expected %0b actual %0b",
                           $time, want.covered, rsp_covered);
               end
            end
         end
         // Predict with the settings in force before any write at this edge.
         if (start && !busy) begin
            want.covered = shape_covers(req_pixel_x, req_pixel_y);
            want.pixel = want.covered ? blend_fill(req_background_pixel)
                                      : req_background_pixel;
            expected_pixels.push_back(want);
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_SHAPE_MODE:    mode = csr_wdata[1:0];
               CSR_ORIGIN_X:      org_x = csr_wdata[10:0];
               CSR_ORIGIN_Y:      org_y = csr_wdata[10:0];
               CSR_SHAPE_WIDTH:   box_w = csr_wdata[9:0];
               CSR_SHAPE_HEIGHT:  box_h = csr_wdata[9:0];
               CSR_CORNER_RADIUS: radius = csr_wdata[7:0];
               CSR_FILL_COLOR:    fill_rgb = csr_wdata[23:0];
               CSR_BLEND_ALPHA:   fill_alpha = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      pixels_in_flight <= expected_pixels.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the shape alpha blend fill block
// Programs a series of shapes, colors and opacities, streams pixels through
// the block with random gaps, and leaves its checking to sabf_scoreboard. A
// directed opening hits the shape edges and the special cases, then random
// shapes and pixels follow.
// ----------------------------------------------------------------------------
module tb_top
   import sabf_pkg::*;
();

   // Roughly how many pixel items the run sends before it winds down.
   localparam int PIXEL_TARGET = 1250;
   // Watchdog in clock cycles, well above the length of a correct run, even
   // with every gap at its longest.
   localparam int CYCLE_LIMIT = 300000;
   // Items in this window get no random gaps; only the pauses between shapes remain.
   localparam int CALM_FIRST = 500;
   localparam int CALM_LAST  = 800;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [8:0]                 req_pixel_x = '0;
   logic [7:0]                 req_pixel_y = '0;
   logic [31:0]                req_background_pixel = '0;
   logic                       rsp_valid;
   logic [31:0]                rsp_result_pixel;
   logic                       rsp_covered;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int mismatch_count;
   int pixels_in_flight;
   int pixels_sent;
   int cycle_count;

   // The shape currently programmed, kept so that random pixels can be
   // aimed at it and not just scattered over the frame.
   int cur_ox;
   int cur_oy;
   int cur_w;
   int cur_h;
   int cur_r;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   shape_alpha_blend_fill dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_pixel_x          (req_pixel_x),
      .req_pixel_y          (req_pixel_y),
      .req_background_pixel (req_background_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_result_pixel     (rsp_result_pixel),
      .rsp_covered          (rsp_covered),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   sabf_scoreboard u_scoreboard (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_pixel_x          (req_pixel_x),
      .req_pixel_y          (req_pixel_y),
      .req_background_pixel (req_background_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_result_pixel     (rsp_result_pixel),
      .rsp_covered          (rsp_covered),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .pixels_in_flight     (pixels_in_flight)
   );

   // One register write. The bits above the register's width get random
   // junk, since the block must ignore them.
   task automatic write_reg(csr_index_type idx, int value, int width);
      logic [23:0] mask;
      mask = (width >= 24) ? 24'hffffff : 24'((1 << width) - 1);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (24'($urandom) & ~mask) | (24'(value) & mask);
      @(posedge clock);
   endtask

   // Programs a whole shape. Called only at a rising edge with nothing in
   // flight, so the new settings never meet an item that is half done.
   task automatic set_shape(int mode, int ox, int oy, int w, int h, int r,
                            int color, int alpha);
      cur_ox = ox;
      cur_oy = oy;
      cur_w = w;
      cur_h = h;
      cur_r = r;
      write_reg(CSR_SHAPE_MODE, mode, 2);
      write_reg(CSR_ORIGIN_X, ox, 11);
      write_reg(CSR_ORIGIN_Y, oy, 11);
      write_reg(CSR_SHAPE_WIDTH, w, 10);
      write_reg(CSR_SHAPE_HEIGHT, h, 10);
      write_reg(CSR_CORNER_RADIUS, r, 8);
      write_reg(CSR_FILL_COLOR, color, 24);
      write_reg(CSR_BLEND_ALPHA, alpha, 8);
      csr_write_enable <= 1'b0;
   endtask

   // Offers one pixel and returns at the edge that takes it. start stays
   // high when the next item follows at once; a gap lowers it first.
   task automatic send_pixel(int x, int y, logic [31:0] bg);
      bit calm;
      calm = pixels_sent >= CALM_FIRST && pixels_sent < CALM_LAST;
      if (!calm && $urandom_range(0, 99) < 3) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_pixel_x <= 9'(x);
      req_pixel_y <= 8'(y);
      req_background_pixel <= bg;
      do @(posedge clock); while (busy);
      pixels_sent++;
   endtask

   // Stops offering items and waits until every result has come back. The
   // in-flight count moves on rising edges, so it is read on falling ones.
   task automatic drain_pixels();
      start <= 1'b0;
      do @(negedge clock); while (pixels_in_flight != 0);
      @(posedge clock);
   endtask

   function automatic int pick_origin();
      if ($urandom_range(0, 99) < 10) begin
         case ($urandom_range(0, 2))
            0: return -1024;
            1: return 1023;
            default: return int'($urandom_range(0, 2047)) - 1024;
         endcase
      end
      return int'($urandom_range(0, 360)) - 40;
   endfunction

   function automatic int pick_size();
      if ($urandom_range(0, 99) < 10) begin
         case ($urandom_range(0, 2))
            0: return 0;
            1: return 1023;
            default: return $urandom_range(0, 1023);
         endcase
      end
      return $urandom_range(1, 200);
   endfunction

   function automatic int pick_alpha();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return 0;
      if (roll < 30) return 255;
      return $urandom_range(0, 255);
   endfunction

   // A coordinate near the shape along one axis, clamped into the frame.
   // Falls back to anywhere in the frame when the shape lies outside it.
   function automatic int pick_near(int lo, int hi, int limit);
      if (lo < 0) lo = 0;
      if (hi > limit - 1) hi = limit - 1;
      if (lo > hi) return $urandom_range(0, limit - 1);
      return $urandom_range(lo, hi);
   endfunction

   task automatic random_shape();
      int mode;
      int w;
      int h;
      int r;
      int cap;
      mode = ($urandom_range(0, 99) < 6) ? 3 : $urandom_range(0, 2);
      w = pick_size();
      h = pick_size();
      if (mode == SHAPE_CIRCLE) begin
         r = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 120)
                                          : $urandom_range(121, 255);
      end else if (mode == SHAPE_ROUNDED && $urandom_range(0, 99) < 80) begin
         // Mostly corners that fit the box; the rest may overlap.
         cap = ((w < h) ? w : h) / 2 + 1;
         r = $urandom_range(0, (cap > 255) ? 255 : cap);
      end else begin
         r = $urandom_range(0, 255);
      end
      set_shape(mode, pick_origin(), pick_origin(), w, h, r,
                int'($urandom_range(0, 24'hffffff)), pick_alpha());
   endtask

   task automatic random_pixel();
      int x;
      int y;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         // Mostly outside the frame, which is never covered, whatever the shape says.
         case ($urandom_range(0, 2))
            0: begin
               x = $urandom_range(FRAME_WIDTH, 511);
               y = $urandom_range(0, 255);
            end
            1: begin
               x = $urandom_range(0, 511);
               y = $urandom_range(FRAME_HEIGHT, 255);
            end
            default: begin
               x = $urandom_range(0, 511);
               y = $urandom_range(0, 255);
            end
         endcase
      end else if (roll < 60) begin
         // Aimed at the shape's box, with a margin so edges get crossed.
         x = pick_near(cur_ox - cur_r - 2,
                       cur_ox + ((cur_w > cur_r) ? cur_w : cur_r) + 2, FRAME_WIDTH);
         y = pick_near(cur_oy - cur_r - 2,
                       cur_oy + ((cur_h > cur_r) ? cur_h : cur_r) + 2, FRAME_HEIGHT);
      end else begin
         x = $urandom_range(0, FRAME_WIDTH - 1);
         y = $urandom_range(0, FRAME_HEIGHT - 1);
      end
      send_pixel(x, y, $urandom);
   endtask

   // Watchdog: a hang or a lost result ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      pixels_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Plain rectangle, opaque: both inside corners, one step past each
      // edge, and the two extreme background values.
      set_shape(SHAPE_RECT, 10, 20, 5, 3, 0, 24'h123456, 255);
      send_pixel(10, 20, 32'h00000000);
      send_pixel(14, 22, 32'hffffffff);
      send_pixel(15, 22, 32'h89abcdef);
      send_pixel(14, 23, 32'h01020304);
      send_pixel(9, 20, 32'hffffffff);
      send_pixel(10, 19, 32'h00000000);
      send_pixel(12, 21, 32'h7f7f7f7f);
      drain_pixels();

      // Largest rectangle at the origin with zero opacity: covered pixels
      // keep their color but gain a full alpha byte. Pixels past the frame
      // edge are inside the box yet must pass through.
      set_shape(SHAPE_RECT, 0, 0, 1023, 1023, 0, 24'hffffff, 0);
      send_pixel(0, 0, 32'h00a5a5a5);
      send_pixel(FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 32'h12345678);
      send_pixel(FRAME_WIDTH, 0, 32'h87654321);
      send_pixel(511, 255, 32'hdeadbeef);
      drain_pixels();

      // Circle of radius zero covers its center and nothing else.
      set_shape(SHAPE_CIRCLE, 100, 100, 0, 0, 0, 24'hff8000, 128);
      send_pixel(100, 100, 32'h00204060);
      send_pixel(101, 100, 32'h00204060);
      drain_pixels();

      // Widest circle, once with the most negative origin, then centered.
      set_shape(SHAPE_CIRCLE, -1024, -1024, 0, 0, 255, 24'h00ff00, 200);
      send_pixel(0, 0, 32'h11223344);
      drain_pixels();
      set_shape(SHAPE_CIRCLE, 160, 100, 0, 0, 255, 24'h00ff00, 200);
      send_pixel(0, 0, 32'h11223344);
      drain_pixels();

      // Rounded rectangle: the cut corner, a point just inside the arc, the middle
      // and the far corner.
      set_shape(SHAPE_ROUNDED, 50, 50, 20, 10, 4, 24'h0000ff, 77);
      send_pixel(50, 50, 32'hcafef00d);
      send_pixel(52, 51, 32'hcafef00d);
      send_pixel(60, 55, 32'hcafef00d);
      send_pixel(69, 59, 32'hcafef00d);
      drain_pixels();

      // The unused shape mode covers nothing, even with a frame-sized box.
      set_shape(3, 0, 0, 1023, 1023, 255, 24'hffffff, 255);
      send_pixel(5, 5, 32'h55555555);
      drain_pixels();

      // Empty rectangles: zero width at the origin, then zero height at the far origin.
      set_shape(SHAPE_RECT, 0, 0, 0, 100, 0, 24'hffffff, 255);
      send_pixel(0, 0, 32'haaaaaaaa);
      drain_pixels();
      set_shape(SHAPE_RECT, 1023, 1023, 100, 0, 0, 24'hffffff, 255);
      send_pixel(0, 0, 32'haaaaaaaa);
      drain_pixels();

      // Random shapes, each with a batch of pixels. The block must be empty
      // before the next shape goes in.
      while (pixels_sent < PIXEL_TARGET) begin
         random_shape();
         repeat ($urandom_range(20, 80)) random_pixel();
         drain_pixels();
      end

      // Wait on to catch any stray result after the last one.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
